// ----- src/trm_pkg.sv -----
// Shared types and constants of the three-phase rms meter.
// Used by trm_ctrl, trm_dp and three_phase_rms_meter; depends on nothing.
package trm_pkg;

  localparam int NumCh = 6;

  // Width of one raw ADC sample; the stream and register layout is built on it.
  localparam int SampleBits = 12;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegVoltZero  = 3'd0;
  localparam logic [2:0] RegCurZeroA  = 3'd1;
  localparam logic [2:0] RegCurZeroB  = 3'd2;
  localparam logic [2:0] RegCurZeroC  = 3'd3;
  localparam logic [2:0] RegDeadZone  = 3'd4;
  localparam logic [2:0] RegVoltGain  = 3'd5;
  localparam logic [2:0] RegCurGain   = 3'd6;
  localparam logic [2:0] RegCurOffset = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture a sample set
    logic       eval;      // compute square and line term of channel ch
    logic       div_start; // start division of the sum pair
    logic       div_line;  // divide the line sum instead of the main sum
    logic       sqrt_start;
    logic       store_rms; // keep root as rms
    logic       store_line;
    logic       update;    // apply window update of channel ch
    logic       close;     // window closes at this update
    logic [2:0] ch;
  } trm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic above;   // square of channel ch is above the dead zone
    logic armed;   // dead flag of channel ch
    logic cnt_zero;
  } trm_sts_t;

endpackage

// ----- src/trm_dp.sv -----
// Datapath of the rms meter: sample history, accumulators, serial divider
// and serial square root. Depends on trm_pkg.
module trm_dp #(
  parameter int MaxWindow  = 1024,
  parameter int SampleBits = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trm_pkg::trm_cmd_t     cmd_i,
  output trm_pkg::trm_sts_t     sts_o,
  input  logic [6*SampleBits-1:0] samples_i,
  input  logic [SampleBits-1:0] volt_zero_i,
  input  logic [SampleBits-1:0] cur_zero_a_i,
  input  logic [SampleBits-1:0] cur_zero_b_i,
  input  logic [SampleBits-1:0] cur_zero_c_i,
  input  logic [23:0]           dead_zone_i,
  input  logic [1:0]            phase_i,
  output logic [11:0]           root_o
);
  localparam int SqW  = 2 * SampleBits;
  localparam int CntW = $clog2(MaxWindow + 1);
  localparam int SumW = SqW + CntW;
  localparam int AccW = SumW + 1;      // sum of current and previous window
  localparam int LnW  = AccW + 1;
  localparam int CW   = CntW + 1;
  localparam int StW  = $clog2(LnW + 1);
  localparam int RootW = (LnW + 1) / 2;
  localparam int RadW  = 2 * RootW;    // radicand padded to whole bit pairs

  logic [SampleBits-1:0] older_q [6];
  logic [SampleBits-1:0] old_q   [6];
  logic [SampleBits-1:0] med_q   [6];
  logic [5:0]            dead_q;
  logic [SumW-1:0]       rsum_q  [6];
  logic [SumW-1:0]       psum_q  [6];
  logic [CntW-1:0]       rcnt_q  [6];
  logic [CntW-1:0]       pcnt_q  [6];
  logic [SumW:0]         rline_q [3];
  logic [SumW:0]         pline_q [3];
  logic [SqW-1:0]        sq_q, line_q;

  logic [SampleBits-1:0] cur [6];
  logic [SampleBits-1:0] zero_sel, m_a, m_b;
  logic [SampleBits-1:0] d_z, d_l;
  logic [2:0]            ch;
  logic [1:0]            lc, nc;

  assign ch = cmd_i.ch;
  assign lc = ch[1:0];
  assign nc = (lc == 2'd2) ? 2'd0 : lc + 2'd1;

  function automatic logic [SampleBits-1:0] med3(
    input logic [SampleBits-1:0] a, input logic [SampleBits-1:0] b,
    input logic [SampleBits-1:0] c);
    logic [SampleBits-1:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++) cur[i] = samples_i[i*SampleBits +: SampleBits];
    case (ch)
      3'd3:    zero_sel = cur_zero_a_i;
      3'd4:    zero_sel = cur_zero_b_i;
      3'd5:    zero_sel = cur_zero_c_i;
      default: zero_sel = volt_zero_i;
    endcase
    m_a = med_q[ch];
    m_b = med_q[{1'b0, nc}];
    d_z = (m_a > zero_sel) ? m_a - zero_sel : zero_sel - m_a;
    d_l = (m_a > m_b) ? m_a - m_b : m_b - m_a;
  end

  logic [CW-1:0]  cnt;
  assign cnt = {1'b0, rcnt_q[ch]} + {1'b0, pcnt_q[ch]};

  assign sts_o.above    = (sq_q > dead_zone_i);
  assign sts_o.armed    = dead_q[ch];
  assign sts_o.cnt_zero = (cnt == '0);

  // Restoring divider, one quotient bit per cycle.
  logic [LnW-1:0] dnum_q, quo_q;
  logic [CW:0]    rem_q;
  logic [CW-1:0]  dden_q;
  logic [StW-1:0] dcnt_q;
  logic           dbusy_q, ddone_q;
  logic [CW:0]    rem_sh;

  assign rem_sh = {rem_q[CW-1:0], dnum_q[LnW-1]};

  // Digit-by-digit square root, two radicand bits per cycle.
  logic [RadW-1:0]  rad_q;
  logic [RootW:0]   root_q;
  logic [RootW+2:0] srem_q;
  logic [StW-1:0]   scnt_q;
  logic             sbusy_q, sdone_q;
  logic [RootW+2:0] s_try, s_rem;

  assign s_rem = {srem_q[RootW:0], rad_q[RadW-1:RadW-2]};
  assign s_try = {root_q, 2'b01};

  logic [RootW:0] root_r;
  assign root_r = (srem_q > {2'b00, root_q}) ? root_q + 1'b1 : root_q;
  assign root_o = root_r[11:0];
  assign sts_o.div_done  = ddone_q;
  assign sts_o.sqrt_done = sdone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        older_q[i] <= '0; old_q[i] <= '0;
        rsum_q[i] <= '0; psum_q[i] <= '0; rcnt_q[i] <= '0; pcnt_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        rline_q[i] <= '0; pline_q[i] <= '0;
      end
      dead_q  <= '0;
      dbusy_q <= 1'b0; ddone_q <= 1'b0;
      sbusy_q <= 1'b0; sdone_q <= 1'b0;
    end else begin
      ddone_q <= 1'b0;
      sdone_q <= 1'b0;
      if (cmd_i.load) begin
        for (int i = 0; i < 6; i++) begin
          if (phase_i == 2'd1) old_q[i] <= cur[i];
          else if (phase_i != 2'd2) older_q[i] <= cur[i];
          else med_q[i] <= med3(older_q[i], old_q[i], cur[i]);
        end
      end
      if (cmd_i.eval) begin
        sq_q   <= d_z * d_z;
        line_q <= d_l * d_l;
      end
      if (cmd_i.update) begin
        if (!sts_o.above) begin
          dead_q[ch] <= 1'b1;
        end else if (cmd_i.close) begin
          dead_q[ch] <= 1'b0;
          psum_q[ch] <= rsum_q[ch];
          pcnt_q[ch] <= rcnt_q[ch];
          rsum_q[ch] <= SumW'(sq_q);
          rcnt_q[ch] <= CntW'(1);
          if (ch < 3'd3) begin
            pline_q[lc] <= rline_q[lc];
            rline_q[lc] <= (SumW+1)'(line_q);
          end
        end else if (rcnt_q[ch] < CntW'(MaxWindow)) begin
          rsum_q[ch] <= rsum_q[ch] + SumW'(sq_q);
          rcnt_q[ch] <= rcnt_q[ch] + 1'b1;
          if (ch < 3'd3) rline_q[lc] <= rline_q[lc] + (SumW+1)'(line_q);
        end
      end
      if (cmd_i.div_start) begin
        dnum_q  <= cmd_i.div_line ? LnW'(rline_q[lc]) + LnW'(pline_q[lc])
                                  : LnW'(rsum_q[ch]) + LnW'(psum_q[ch]);
        dden_q  <= cnt;
        rem_q   <= '0;
        dcnt_q  <= StW'(LnW);
        dbusy_q <= 1'b1;
      end else if (dbusy_q) begin
        if (rem_sh >= {1'b0, dden_q}) begin
          rem_q <= rem_sh - {1'b0, dden_q};
          quo_q <= {quo_q[LnW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[LnW-2:0], 1'b0};
        end
        dnum_q <= {dnum_q[LnW-2:0], 1'b0};
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == StW'(1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
      if (cmd_i.sqrt_start) begin
        rad_q   <= RadW'(quo_q);
        root_q  <= '0;
        srem_q  <= '0;
        scnt_q  <= StW'(RootW);
        sbusy_q <= 1'b1;
      end else if (sbusy_q) begin
        if (s_rem >= s_try) begin
          srem_q <= s_rem - s_try;
          root_q <= {root_q[RootW-1:0], 1'b1};
        end else begin
          srem_q <= s_rem;
          root_q <= {root_q[RootW-1:0], 1'b0};
        end
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        scnt_q <= scnt_q - 1'b1;
        if (scnt_q == StW'(1)) begin
          sbusy_q <= 1'b0;
          sdone_q <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- src/trm_ctrl.sv -----
// Sequencer of the rms meter: walks the six channels and drives the
// datapath and the result register. Depends on trm_pkg.
module trm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_req_i,
  output logic              in_ready_o,
  output logic              out_load_o,
  input  logic              out_free_i,
  output logic [1:0]        phase_o,
  output trm_pkg::trm_cmd_t cmd_o,
  input  trm_pkg::trm_sts_t sts_i
);
  localparam logic [3:0] SIdle = 4'd0, SEval = 4'd1, SDec = 4'd2,
                         SDiv = 4'd3, SSqrt = 4'd4, SLDiv = 4'd5,
                         SLSqrt = 4'd6, SOut = 4'd7, SNext = 4'd8,
                         SWait = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] ch_q, ch_d;
  logic [1:0] phase_q, phase_d;
  logic       close_q, close_d;

  assign phase_o    = phase_q;
  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q; ch_d = ch_q; phase_d = phase_q;
    close_d = close_q;
    cmd_o = '0;
    cmd_o.ch = ch_q;
    cmd_o.close = close_q;
    out_load_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_req_i) begin
          cmd_o.load = 1'b1;
          if (phase_q == 2'd2) begin
            phase_d = 2'd0;
            ch_d = 3'd0;
            state_d = SEval;
          end else begin
            phase_d = (phase_q == 2'd1) ? 2'd2 : 2'd1;
          end
        end
      end
      SEval: begin
        cmd_o.eval = 1'b1;
        state_d = SDec;
      end
      SDec: begin
        close_d = sts_i.above && sts_i.armed;
        if (sts_i.above && sts_i.armed && !sts_i.cnt_zero) begin
          cmd_o.div_start = 1'b1;
          state_d = SDiv;
        end else if (sts_i.above && sts_i.armed) begin
          state_d = SWait;
        end else begin
          state_d = SNext;
        end
      end
      SDiv: if (sts_i.div_done) begin
        cmd_o.sqrt_start = 1'b1;
        state_d = SSqrt;
      end
      SSqrt: if (sts_i.sqrt_done) begin
        cmd_o.store_rms = 1'b1;
        if (ch_q < 3'd3) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_line = 1'b1;
          state_d = SLDiv;
        end else begin
          state_d = SWait;
        end
      end
      SLDiv: if (sts_i.div_done) begin
        cmd_o.sqrt_start = 1'b1;
        state_d = SLSqrt;
      end
      SLSqrt: if (sts_i.sqrt_done) begin
        cmd_o.store_line = 1'b1;
        state_d = SWait;
      end
      SWait: if (out_free_i) begin
        out_load_o = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        state_d = SNext;
      end
      SNext: begin
        // The last channel waits until the held result can be flushed.
        if (ch_q != 3'd5 || out_free_i) begin
          cmd_o.update = 1'b1;
          if (ch_q == 3'd5) state_d = SIdle;
          else begin
            ch_d = ch_q + 1'b1;
            state_d = SEval;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ch_q <= '0; phase_q <= '0;
      close_q <= 1'b0;
    end else begin
      state_q <= state_d; ch_q <= ch_d; phase_q <= phase_d;
      close_q <= close_d;
    end
  end
endmodule

// ----- src/three_phase_rms_meter.sv -----
// Top level of the three-phase true-rms meter.
// Instantiates trm_ctrl and trm_dp; uses trm_pkg.
//
// The meter takes one set of six 12-bit ADC samples per request. Every third
// set each channel forms the median of its last three samples, squares its
// deviation from zero and accumulates it over a window closed at the first
// sample above the dead zone after a dead-zone sample. On a close the block
// reports rounded sqrt((window + previous window) / count), the line value for
// voltage phases, and gain-scaled values. A non-median set only stores its
// samples. A reporting channel adds one serial division (37 quotient bits) and
// one serial square root (19 steps), twice for voltage channels, plus the
// hand-over to the output; when its windows are empty it skips both. The
// input stays closed while a median set is scanned; the shared divider and
// root unit serve one channel at a time. Results are held in an output
// register; the sequencer waits while it is full. Because the last result of
// a set is only known after all six channels are scanned, one result is held
// back in a pending register and marked last at the end; the sequencer
// finishes a set only once the output register can take it.
module three_phase_rms_meter #(
  parameter int MaxWindow  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: volt_a, volt_b, volt_c, amp_a, amp_b, amp_c, 12 bits each
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: channel[2:0], rms_counts[14:3], line_rms_counts[26:15],
  // rms_scaled[54:27], line_scaled[82:55], zero fill to 88 bits
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [11:0] vzero_q, czero_a_q, czero_b_q, czero_c_q;
  logic [23:0] dead_q;
  logic [15:0] vgain_q, cgain_q, coff_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vzero_q <= 12'd2030; czero_a_q <= 12'd2034; czero_b_q <= 12'd2037;
      czero_c_q <= 12'd2025; dead_q <= 24'd400; vgain_q <= 16'd17859;
      cgain_q <= 16'd405; coff_q <= 16'd809;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        trm_pkg::RegVoltZero:  vzero_q   <= pwdata[11:0];
        trm_pkg::RegCurZeroA:  czero_a_q <= pwdata[11:0];
        trm_pkg::RegCurZeroB:  czero_b_q <= pwdata[11:0];
        trm_pkg::RegCurZeroC:  czero_c_q <= pwdata[11:0];
        trm_pkg::RegDeadZone:  dead_q    <= pwdata[23:0];
        trm_pkg::RegVoltGain:  vgain_q   <= pwdata[15:0];
        trm_pkg::RegCurGain:   cgain_q   <= pwdata[15:0];
        trm_pkg::RegCurOffset: coff_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      trm_pkg::RegVoltZero:  prdata = {20'd0, vzero_q};
      trm_pkg::RegCurZeroA:  prdata = {20'd0, czero_a_q};
      trm_pkg::RegCurZeroB:  prdata = {20'd0, czero_b_q};
      trm_pkg::RegCurZeroC:  prdata = {20'd0, czero_c_q};
      trm_pkg::RegDeadZone:  prdata = {8'd0, dead_q};
      trm_pkg::RegVoltGain:  prdata = {16'd0, vgain_q};
      trm_pkg::RegCurGain:   prdata = {16'd0, cgain_q};
      trm_pkg::RegCurOffset: prdata = {16'd0, coff_q};
      default:               prdata = '0;
    endcase
  end

  trm_pkg::trm_cmd_t cmd;
  trm_pkg::trm_sts_t sts;
  logic [1:0]  phase;
  logic [11:0] root;
  logic        out_load;
  logic [6*trm_pkg::SampleBits-1:0] samples;

  always_comb begin
    for (int i = 0; i < 6; i++)
      samples[i*trm_pkg::SampleBits +: trm_pkg::SampleBits] =
        s_axis_tdata[i*trm_pkg::SampleBits +: trm_pkg::SampleBits];
  end

  // Pending result, flushed to the output register when a newer result
  // arrives or the set ends.
  logic        pend_q, oval_q, olast_q;
  logic [82:0] pend_data_q, odata_q;
  logic [11:0] rms_q, line_q;
  logic        end_set;
  logic        free;

  trm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_req_i   (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .out_free_i (free),
    .phase_o    (phase),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  trm_dp #(.MaxWindow(MaxWindow), .SampleBits(trm_pkg::SampleBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .samples_i    (samples),
    .volt_zero_i  (vzero_q),
    .cur_zero_a_i (czero_a_q),
    .cur_zero_b_i (czero_b_q),
    .cur_zero_c_i (czero_c_q),
    .dead_zone_i  (dead_q),
    .phase_i      (phase),
    .root_o       (root)
  );

  // The result assembly: rms and line roots, scaled with one multiply each.
  logic        volt;
  logic [11:0] rms_v, line_v;
  logic [27:0] rs, ls;
  assign volt   = (cmd.ch < 3'd3);
  assign rms_v  = sts.cnt_zero ? 12'd0 : rms_q;
  assign line_v = (sts.cnt_zero || !volt) ? 12'd0 : line_q;
  assign rs = volt ? 28'(rms_v) * 28'(vgain_q)
                   : 28'(rms_v) * 28'(cgain_q) + 28'(coff_q);
  assign ls = 28'(line_v) * 28'(vgain_q);

  assign free    = !oval_q || m_axis_tready;
  assign end_set = cmd.update && cmd.ch == 3'd5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0; oval_q <= 1'b0; olast_q <= 1'b0;
      pend_data_q <= '0; odata_q <= '0; rms_q <= '0; line_q <= '0;
    end else begin
      if (cmd.store_rms) rms_q <= root;
      if (cmd.store_line) line_q <= root;
      if (out_load) begin
        pend_data_q <= {ls, rs, line_v, rms_v, cmd.ch};
        pend_q <= 1'b1;
        if (pend_q) begin
          odata_q <= pend_data_q; olast_q <= 1'b0; oval_q <= 1'b1;
        end else if (m_axis_tready) begin
          oval_q <= 1'b0;
        end
      end else if (end_set && pend_q && free) begin
        odata_q <= pend_data_q; olast_q <= 1'b1; oval_q <= 1'b1;
        pend_q <= 1'b0;
      end else if (m_axis_tready) begin
        oval_q <= 1'b0;
      end
      if (cmd.eval && cmd.ch == 3'd0) begin
        rms_q <= '0; line_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {5'd0, odata_q};
  assign m_axis_tlast  = olast_q;
endmodule

// ----- tb/sv/tb_three_phase_rms_meter.sv -----
// Testbench of the three-phase rms meter: drives sample sets and register writes,
// predicts every result in its own model and compares field by field.
// Depends on trm_pkg and three_phase_rms_meter.
module tb_three_phase_rms_meter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxWin = 1024;

  // One meter result as it leaves the block.
  typedef struct packed {
    logic [2:0]  channel;
    logic [11:0] rms_counts;
    logic [11:0] line_rms_counts;
    logic [27:0] rms_scaled;
    logic [27:0] line_scaled;
    logic        last;
  } meter_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: volt_a, volt_b, volt_c, amp_a, amp_b, amp_c, 12 bits each
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: channel, rms_counts, line_rms_counts, rms_scaled, line_scaled
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  three_phase_rms_meter dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state: the register copies and the per-channel window state.
  logic [11:0] zero_code [6];
  logic [23:0] dead_zone;
  logic [15:0] volt_gain, cur_gain, cur_offset;
  int unsigned       phase;
  logic [11:0]       older_s [6], old_s [6];
  logic [5:0]        armed;
  longint unsigned   win_sum [6], win_cnt [6], prev_sum [6], prev_cnt [6];
  longint unsigned   win_line [3], prev_line [3];

  logic [71:0]   sample_sets [$];
  meter_result_t pending_results [$];
  bit failed = 1'b0;
  int unsigned accepted_sets = 0;

  function automatic longint unsigned rounded_root(longint unsigned x);
    longint unsigned r, b, v;
    r = 0; v = x; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  function automatic int unsigned mid_of_three(int unsigned a, int unsigned b, int unsigned c);
    int unsigned lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) return lo;
    if (c >= hi) return hi;
    return c;
  endfunction

  function automatic int unsigned squared_gap(int unsigned a, int unsigned b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Applies one accepted sample set and queues the results it closes.
  task automatic predict_windows(input logic [71:0] set);
    int unsigned cur [6], med [6];
    int unsigned sq, line;
    longint unsigned cnt, rms, lrms, rs, ls;
    meter_result_t res;
    int n;
    n = 0;
    for (int c = 0; c < 6; c++) cur[c] = set[12*c +: 12];
    if (phase == 1) begin
      for (int c = 0; c < 6; c++) old_s[c] = cur[c];
      phase = 2;
      return;
    end
    if (phase != 2) begin
      for (int c = 0; c < 6; c++) older_s[c] = cur[c];
      phase = 1;
      return;
    end
    phase = 0;
    for (int c = 0; c < 6; c++) med[c] = mid_of_three(older_s[c], old_s[c], cur[c]);
    for (int c = 0; c < 6; c++) begin
      sq = squared_gap(med[c], zero_code[c]);
      line = (c < 3) ? squared_gap(med[c], med[(c + 1) % 3]) : 0;
      if (sq <= dead_zone) begin
        armed[c] = 1'b1;
        continue;
      end
      if (armed[c]) begin
        armed[c] = 1'b0;
        cnt = win_cnt[c] + prev_cnt[c];
        rms = 0; lrms = 0;
        if (cnt != 0) begin
          rms = rounded_root((win_sum[c] + prev_sum[c]) / cnt);
          if (c < 3) lrms = rounded_root((win_line[c] + prev_line[c]) / cnt);
        end
        rms &= 64'hFFF;
        lrms &= 64'hFFF;
        if (c < 3) begin
          rs = rms * volt_gain;
          ls = lrms * volt_gain;
        end else begin
          rs = rms * cur_gain + cur_offset;
          ls = 0;
        end
        res.channel = c[2:0];
        res.rms_counts = rms[11:0];
        res.line_rms_counts = lrms[11:0];
        res.rms_scaled = rs[27:0];
        res.line_scaled = ls[27:0];
        res.last = 1'b0;
        pending_results.push_back(res);
        n++;
        prev_sum[c] = win_sum[c];
        prev_cnt[c] = win_cnt[c];
        win_sum[c] = 0;
        win_cnt[c] = 0;
        if (c < 3) begin
          prev_line[c] = win_line[c];
          win_line[c] = 0;
        end
      end
      if (win_cnt[c] < MaxWin) begin
        win_cnt[c]++;
        win_sum[c] += sq;
        if (c < 3) win_line[c] += line;
      end
    end
    if (n > 0) pending_results[$].last = 1'b1;
  endtask

  function automatic int unsigned short_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
  endfunction

  // Sampled handshake of the previous rising edge.
  bit s_axis_tready_seen = 1'b0;
  always @(posedge clk_i) begin
    s_axis_tready_seen <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_windows(s_axis_tdata);
      accepted_sets++;
    end
  end

  // Driver: presents the queued sets with random gaps; inputs move on falling edges.
  int unsigned send_hold = 0;
  bit gaps_on = 1'b1;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(s_axis_tvalid && !s_axis_tready_seen)) begin
        if (s_axis_tvalid) send_hold = gaps_on ? short_gap() : 0;
        if (send_hold > 0) begin
          send_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_sets.size() > 0) begin
          s_axis_tdata <= sample_sets.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    if (!gaps_on) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  // Monitor: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    meter_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.channel = m_axis_tdata[2:0];
      got.rms_counts = m_axis_tdata[14:3];
      got.line_rms_counts = m_axis_tdata[26:15];
      got.rms_scaled = m_axis_tdata[54:27];
      got.line_scaled = m_axis_tdata[82:55];
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ch=%0d rms=%0d", $time, got.channel, got.rms_counts);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected ch=%0d rms=%0d line=%0d rs=%0d ls=%0d last=%0b",
                   $time, want.channel, want.rms_counts, want.line_rms_counts,
                   want.rms_scaled, want.line_scaled, want.last);
          $display("%0t: actual   ch=%0d rms=%0d line=%0d rs=%0d ls=%0d last=%0b",
                   $time, got.channel, got.rms_counts, got.line_rms_counts,
                   got.rms_scaled, got.line_scaled, got.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Register write over the setup and access cycles; the model follows at the write edge.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      trm_pkg::RegVoltZero: for (int c = 0; c < 3; c++) zero_code[c] = val[11:0];
      trm_pkg::RegCurZeroA: zero_code[3] = val[11:0];
      trm_pkg::RegCurZeroB: zero_code[4] = val[11:0];
      trm_pkg::RegCurZeroC: zero_code[5] = val[11:0];
      trm_pkg::RegDeadZone: dead_zone = val[23:0];
      trm_pkg::RegVoltGain: volt_gain = val[15:0];
      trm_pkg::RegCurGain:  cur_gain = val[15:0];
      trm_pkg::RegCurOffset: cur_offset = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Waits until the queued sets are taken and every expectation has arrived.
  task automatic drain();
    int unsigned spent;
    spent = sample_sets.size() + accepted_sets;
    while (accepted_sets < spent || s_axis_tvalid) @(posedge clk_i);
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  function automatic logic [71:0] pack_set(int unsigned va, int unsigned vb, int unsigned vc,
                                           int unsigned ia, int unsigned ib, int unsigned ic);
    return {ic[11:0], ib[11:0], ia[11:0], vc[11:0], vb[11:0], va[11:0]};
  endfunction

  // Random sets around the zero codes: dead-zone and active groups mixed at random
  // so windows keep closing.
  task automatic queue_wave(int unsigned groups, int unsigned spread);
    int unsigned s [6];
    bit quiet;
    for (int g = 0; g < groups; g++) begin
      quiet = $urandom_range(0, 2) == 0;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 6; c++) begin
          if ($urandom_range(0, 19) == 0) s[c] = $urandom_range(0, 4095);
          else if (quiet) s[c] = zero_code[c] + $urandom_range(0, 30) - 15;
          else s[c] = zero_code[c] + $urandom_range(0, 2 * spread) - spread;
          if (s[c] > 4095) s[c] = $urandom_range(0, 1) ? 4095 : 0;
        end
        sample_sets.push_back(pack_set(s[0], s[1], s[2], s[3], s[4], s[5]));
      end
    end
  endtask

  initial begin
    zero_code = '{2030, 2030, 2030, 2034, 2037, 2025};
    dead_zone = 400; volt_gain = 17859; cur_gain = 405; cur_offset = 809;
    phase = 0; armed = '0;
    for (int c = 0; c < 6; c++) begin
      older_s[c] = '0; old_s[c] = '0;
      win_sum[c] = 0; win_cnt[c] = 0; prev_sum[c] = 0; prev_cnt[c] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      win_line[c] = 0; prev_line[c] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a dead-zone group at the reset zero codes arms every channel, then
    // full-scale extremes close empty windows, and later groups close windows with content.
    sample_sets.push_back(pack_set(2030, 2030, 2030, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(2030, 2030, 2030, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(2030, 2030, 2030, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(4095, 0, 4095, 0, 4095, 0));
    sample_sets.push_back(pack_set(4095, 0, 4095, 0, 4095, 0));
    sample_sets.push_back(pack_set(4095, 0, 4095, 0, 4095, 0));
    sample_sets.push_back(pack_set(2035, 2030, 2025, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(0, 4095, 2030, 4095, 0, 2025));
    sample_sets.push_back(pack_set(2030, 2030, 2030, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(0, 4095, 0, 4095, 0, 4095));
    sample_sets.push_back(pack_set(0, 4095, 0, 4095, 0, 4095));
    sample_sets.push_back(pack_set(2555, 1365, 2730, 3000, 1000, 2222));
    sample_sets.push_back(pack_set(1365, 2730, 2555, 2048, 2048, 2048));
    sample_sets.push_back(pack_set(2030, 2030, 2030, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(2030, 2030, 2030, 2034, 2037, 2025));
    sample_sets.push_back(pack_set(3000, 1000, 3500, 100, 4000, 2500));
    sample_sets.push_back(pack_set(3100, 1100, 3400, 200, 3900, 2600));
    sample_sets.push_back(pack_set(2900, 900, 3600, 300, 3800, 2400));
    drain();

    // Random phases with register sets at the extremes and in between.
    queue_wave(30, 300);
    drain();
    write_reg(trm_pkg::RegVoltZero, 0);
    write_reg(trm_pkg::RegCurZeroA, 4095);
    write_reg(trm_pkg::RegCurZeroB, 32'hFFFF_F000);
    write_reg(trm_pkg::RegCurZeroC, 2048);
    write_reg(trm_pkg::RegDeadZone, 0);
    write_reg(trm_pkg::RegVoltGain, 65535);
    write_reg(trm_pkg::RegCurGain, 65535);
    write_reg(trm_pkg::RegCurOffset, 65535);
    queue_wave(15, 2000);
    drain();
    write_reg(trm_pkg::RegVoltZero, 4095);
    write_reg(trm_pkg::RegCurZeroA, 0);
    write_reg(trm_pkg::RegCurZeroB, 1234);
    write_reg(trm_pkg::RegCurZeroC, 4095);
    write_reg(trm_pkg::RegDeadZone, 24'hFFFFFF);
    write_reg(trm_pkg::RegVoltGain, 0);
    write_reg(trm_pkg::RegCurGain, 0);
    write_reg(trm_pkg::RegCurOffset, 0);
    queue_wave(8, 2000);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_reg(trm_pkg::RegVoltZero, $urandom_range(1500, 2500));
      write_reg(trm_pkg::RegCurZeroA, $urandom_range(0, 4095));
      write_reg(trm_pkg::RegCurZeroB, $urandom_range(1500, 2500));
      write_reg(trm_pkg::RegCurZeroC, $urandom_range(1500, 2500));
      write_reg(trm_pkg::RegDeadZone, $urandom_range(0, 5000));
      write_reg(trm_pkg::RegVoltGain, $urandom_range(0, 65535));
      write_reg(trm_pkg::RegCurGain, $urandom_range(0, 65535));
      write_reg(trm_pkg::RegCurOffset, $urandom_range(0, 65535));
      gaps_on = (p != 1);
      queue_wave(15, $urandom_range(100, 2047));
      drain();
    end
    gaps_on = 1'b1;
    if (failed || pending_results.size() != 0) begin
      $display("three_phase_rms_meter: mismatch");
    end else begin
      $display("three_phase_rms_meter: match");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("three_phase_rms_meter: mismatch");
    $finish;
  end
endmodule
